// ----- rtl/cfr_pkg.sv -----
// Shared constants and types of the command frame receiver.
package cfr_pkg;

    // Longest data field that a frame may announce.
    localparam int MAX_PAYLOAD_DEF = 16;

    // Framing bytes.
    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;

    // Number of data bytes kept for classification.
    localparam int HEAD_DEPTH = 4;

    // Parser phase codes.
    typedef logic [2:0] phase_t;
    localparam phase_t PH_START = 3'd0;
    localparam phase_t PH_ID    = 3'd1;
    localparam phase_t PH_LEN   = 3'd2;
    localparam phase_t PH_DATA  = 3'd3;
    localparam phase_t PH_SUM   = 3'd4;

    // Frame status codes.
    typedef logic [2:0] status_t;
    localparam status_t ST_JOB     = 3'd0;
    localparam status_t ST_STOP    = 3'd1;
    localparam status_t ST_RESET   = 3'd2;
    localparam status_t ST_IGNORED = 3'd3;
    localparam status_t ST_BADSUM  = 3'd4;

    // Configuration register indexes.
    typedef logic [2:0] cfg_index_t;
    localparam cfg_index_t CFG_JOB_ID     = 3'd0;
    localparam cfg_index_t CFG_STOP_ID    = 3'd1;
    localparam cfg_index_t CFG_RESTART_ID = 3'd2;
    localparam cfg_index_t CFG_HARVEST    = 3'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0] JOB_ID_RST     = 8'd1;
    localparam logic [7:0] STOP_ID_RST    = 8'd2;
    localparam logic [7:0] RESTART_ID_RST = 8'd3;
    localparam logic [7:0] HARVEST_RST    = 8'd1;

endpackage

// ----- rtl/command_frame_receiver.sv -----
// Command frame receiver: start byte hunt, length check, checksum and frame classification.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+----------------------------------
//  in      | in_valid / in_stall   | rx_byte
//  out     | out_valid / out_stall | frame_status, job_number
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; each transfer updates the parser state in that cycle.
// A result appears in the output register in the cycle after its checksum byte is taken.
// Only a checksum byte waits on a held result: other bytes flow while the output stalls.
// Reset is asynchronous and active low; it returns the parser to the start byte hunt.
// No clearing pass is needed after reset; configuration writes are always taken.
module command_frame_receiver #(
    parameter int MAX_PAYLOAD = cfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // Received bytes
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,
    // Results
    output logic                out_valid,
    input  logic                out_stall,
    output cfr_pkg::status_t    frame_status,
    output logic [7:0]          job_number,
    // Configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  cfr_pkg::cfg_index_t cfg_index,
    input  logic [7:0]          cfg_data
);

    // Width of the length and byte counters.
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    cfr_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]       id_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] count_reg;
    logic [LEN_W:0]   count_inc;
    logic [7:0]       sum_reg;
    logic [7:0]       head_reg [cfr_pkg::HEAD_DEPTH];

    logic [7:0]       job_id_reg, stop_id_reg, restart_id_reg, harvest_reg;

    logic             out_valid_reg;
    cfr_pkg::status_t status_reg, status_next;
    logic [7:0]       job_reg, job_next;

    logic             in_fire;
    logic             out_free;
    logic             too_long;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_id_reg     <= cfr_pkg::JOB_ID_RST;
            stop_id_reg    <= cfr_pkg::STOP_ID_RST;
            restart_id_reg <= cfr_pkg::RESTART_ID_RST;
            harvest_reg    <= cfr_pkg::HARVEST_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cfr_pkg::CFG_JOB_ID:     job_id_reg     <= cfg_data;
                cfr_pkg::CFG_STOP_ID:    stop_id_reg    <= cfg_data;
                cfr_pkg::CFG_RESTART_ID: restart_id_reg <= cfg_data;
                cfr_pkg::CFG_HARVEST:    harvest_reg    <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // Handshake: the output register is free when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (phase_reg == cfr_pkg::PH_SUM) && !out_free;
    assign in_fire  = in_valid && !in_stall;

    assign too_long  = {1'b0, rx_byte} > 9'(MAX_PAYLOAD);
    assign count_inc = {1'b0, count_reg} + (LEN_W+1)'(1);

    // Next phase of the parser.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            cfr_pkg::PH_ID:   phase_next = cfr_pkg::PH_LEN;
            cfr_pkg::PH_LEN:
            begin
                if (too_long)
                    phase_next = cfr_pkg::PH_START;
                else if (rx_byte == cfr_pkg::ZERO_BYTE)
                    phase_next = cfr_pkg::PH_SUM;
                else
                    phase_next = cfr_pkg::PH_DATA;
            end
            cfr_pkg::PH_DATA:
            begin
                if (count_inc >= {1'b0, len_reg})
                    phase_next = cfr_pkg::PH_SUM;
            end
            cfr_pkg::PH_SUM:  phase_next = cfr_pkg::PH_START;
            default:
            begin
                if (rx_byte == cfr_pkg::START_BYTE)
                    phase_next = cfr_pkg::PH_ID;
                else
                    phase_next = cfr_pkg::PH_START;
            end
        endcase
    end

    // Checksum test and frame classification on the checksum byte.
    always_comb
    begin
        status_next = cfr_pkg::ST_IGNORED;
        job_next    = cfr_pkg::ZERO_BYTE;
        if (rx_byte != sum_reg)
            status_next = cfr_pkg::ST_BADSUM;
        else if (id_reg == job_id_reg)
        begin
            if (len_reg == LEN_W'(cfr_pkg::HEAD_DEPTH) && head_reg[0] == harvest_reg &&
                head_reg[1] == cfr_pkg::ZERO_BYTE && head_reg[2] == cfr_pkg::ZERO_BYTE)
            begin
                status_next = cfr_pkg::ST_JOB;
                job_next    = head_reg[3];
            end
        end
        else if (id_reg == stop_id_reg && len_reg == '0)
            status_next = cfr_pkg::ST_STOP;
        else if (id_reg == restart_id_reg && len_reg == '0)
            status_next = cfr_pkg::ST_RESET;
    end

    // Parser control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= cfr_pkg::PH_START;
        else if (in_fire)
            phase_reg <= phase_next;
    end

    // Frame fields, counter and running sum.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            case (phase_reg)
                cfr_pkg::PH_ID:
                    id_reg <= rx_byte;
                cfr_pkg::PH_LEN:
                begin
                    len_reg   <= LEN_W'(rx_byte);
                    count_reg <= '0;
                    sum_reg   <= id_reg + rx_byte;
                end
                cfr_pkg::PH_DATA:
                begin
                    if (count_reg < LEN_W'(cfr_pkg::HEAD_DEPTH))
                        head_reg[count_reg[1:0]] <= rx_byte;
                    count_reg <= count_inc[LEN_W-1:0];
                    sum_reg   <= sum_reg + rx_byte;
                end
                default: ;
            endcase
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_fire && (phase_reg == cfr_pkg::PH_SUM);
    end

    always_ff @(posedge clk)
    begin
        if (out_free && in_fire && phase_reg == cfr_pkg::PH_SUM)
        begin
            status_reg <= status_next;
            job_reg    <= job_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_status = status_reg;
    assign job_number   = job_reg;

    // A checksum byte always leaves a result and restarts the hunt.
    a_sum_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && phase_reg == cfr_pkg::PH_SUM |=> out_valid && phase_reg == cfr_pkg::PH_START)
        else $error("checksum byte left no result");

    // Other bytes never create a result.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_fire && phase_reg == cfr_pkg::PH_SUM) && out_free |=> !out_valid)
        else $error("result without a checksum byte");

    // A job number is only reported with a harvest job.
    a_job_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_status != cfr_pkg::ST_JOB |-> job_number == cfr_pkg::ZERO_BYTE)
        else $error("job number set on a non-job result");

    // The data counter stays below the announced length.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == cfr_pkg::PH_DATA |-> count_reg < len_reg)
        else $error("data counter overran the frame length");

    // Reported status codes stay within the defined set.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_status <= cfr_pkg::ST_BADSUM)
        else $error("undefined frame status");

endmodule
